@@ rtl/tem_pkg.sv @@
// ----------------------------------------------------------------------------
// tem_pkg: shared types and constants of the timestamp event matcher
// Item and result layouts, queue entry layout, outcome and kind codes,
// sequencer states and the comparator status group.
// ----------------------------------------------------------------------------
package tem_pkg;

  localparam int IDX_W   = 10;
  localparam int SEC_W   = 32;
  localparam int NS_W    = 30;
  localparam int MODK_W  = 4;
  localparam int IDX_MAX = (1 << IDX_W) - 1;

  // Seconds from the 1970 epoch to the 1990 epoch.
  localparam logic [SEC_W-1:0] EPOCH_SHIFT = 32'((20 * 365 + 5) * 24 * 3600);

  localparam logic [1:0] KIND_QUEUE  = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_SWEEP  = 2'd2;

  localparam logic [2:0] OUT_MATCHED  = 3'd0;
  localparam logic [2:0] OUT_MISSING  = 3'd1;
  localparam logic [2:0] OUT_TIMEDOUT = 3'd2;
  localparam logic [2:0] OUT_CLEAN    = 3'd3;
  localparam logic [2:0] OUT_REFUSED  = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] event_index;
    logic [SEC_W-1:0] seconds;
    logic [NS_W-1:0]  nanoseconds;
    logic             slow_update;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] event_index_res;
    logic [2:0]       outcome;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
    logic             slow;
  } entry_t;

  typedef struct packed {
    logic ge;  // key is not older than the entry
    logic eq;  // key equals the entry
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_APPEND,
    ST_READ,
    ST_CMP,
    ST_FLUSH
  } state_t;

  // Number of restoring subtract steps that reduce a buffer index modulo bc.
  function automatic int mod_steps(input int bc);
    int n;
    n = 0;
    for (int i = 0; i <= IDX_W; i++) begin
      if ((bc << i) <= IDX_MAX) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/tem_ram.sv @@
// ----------------------------------------------------------------------------
// tem_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tem_cmp.sv @@
// ----------------------------------------------------------------------------
// tem_cmp: timestamp comparator
// Orders the key time against a queue entry time, seconds first and then
// nanoseconds, both unsigned. Shared by PV updates and timeout sweeps.
// ----------------------------------------------------------------------------
module tem_cmp
  import tem_pkg::*;
(
  input  logic [SEC_W-1:0] key_sec,
  input  logic [NS_W-1:0]  key_ns,
  input  logic [SEC_W-1:0] ent_sec,
  input  logic [NS_W-1:0]  ent_ns,
  output cmp_t             res
);

  logic sec_eq;
  logic ns_eq;

  assign sec_eq = (key_sec == ent_sec);
  assign ns_eq  = (key_ns == ent_ns);
  assign res.eq = sec_eq && ns_eq;
  assign res.ge = sec_eq ? (key_ns >= ent_ns) : (key_sec > ent_sec);

endmodule

@@ rtl/timestamp_event_matcher.sv @@
// ----------------------------------------------------------------------------
// timestamp_event_matcher: pending event queue with timestamp matching
// Queues events, matches them against PV update times and times them out
// against a sweep cutoff, one queue entry per pass of a shared comparator.
// ----------------------------------------------------------------------------
//  channel  signals                           payload
//  item     item_valid / item_ready / item    item_t (kind, index, time, slow)
//  result   result_valid / result_ready / result  result_t (index, outcome, last)
//
// A queue item passes through ST_IDLE and ST_APPEND, and ST_FLUSH when refused,
// plus one ST_MOD state per index reduction step when BUFFER_COUNT is below 1024.
// An update or sweep passes ST_READ and ST_CMP for each queue entry examined
// (registered RAM read), and ends in ST_FLUSH when it has popped an entry.
// Reset (rst, synchronous) empties the queue; the RAM contents are not cleared.
// A stalled result port holds the sequencer only when a new result must
// be handed over; a result waiting in the output register blocks nothing else.
module timestamp_event_matcher
  import tem_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 64,
  parameter int BUFFER_COUNT = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MOD_STEPS = mod_steps(BUFFER_COUNT);
  localparam int ENT_W     = $bits(entry_t);

  state_t            state, state_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [SEC_W-1:0]  key_sec, key_sec_next;
  logic [NS_W-1:0]   key_ns, key_ns_next;
  logic              slow, slow_next;
  logic              mode_upd, mode_upd_next;
  logic [IDX_W-1:0]  rem, rem_next;
  logic [MODK_W-1:0] mod_k, mod_k_next;
  logic              pend_valid, pend_valid_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [2:0]        pend_outcome, pend_outcome_next;
  logic              out_valid, out_valid_next;
  result_t           out_data, out_data_next;

  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [ENT_W-1:0]  ram_rbits;
  cmp_t              cmp;
  logic              out_free;
  logic [31:0]       divisor;
  logic              queue_full;
  logic [2:0]        pop_outcome;

  tem_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  tem_cmp u_cmp (
    .key_sec (key_sec),
    .key_ns  (key_ns),
    .ent_sec (ram_rdata.sec),
    .ent_ns  (ram_rdata.ns),
    .res     (cmp)
  );

  assign out_free     = !out_valid || result_ready;
  assign divisor      = 32'(BUFFER_COUNT) << mod_k;
  assign queue_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign result_valid = out_valid;
  assign result       = out_data;

  always_comb begin
    if (mode_upd) begin
      pop_outcome = cmp.eq ? OUT_MATCHED : (ram_rdata.slow ? OUT_CLEAN : OUT_MISSING);
    end else begin
      pop_outcome = ram_rdata.slow ? OUT_CLEAN : OUT_TIMEDOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key_sec      <= key_sec_next;
    key_ns       <= key_ns_next;
    slow         <= slow_next;
    mode_upd     <= mode_upd_next;
    rem          <= rem_next;
    mod_k        <= mod_k_next;
    pend_idx     <= pend_idx_next;
    pend_outcome <= pend_outcome_next;
    out_data     <= out_data_next;
  end

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    key_sec_next      = key_sec;
    key_ns_next       = key_ns;
    slow_next         = slow;
    mode_upd_next     = mode_upd;
    rem_next          = rem;
    mod_k_next        = mod_k;
    pend_valid_next   = pend_valid;
    pend_idx_next     = pend_idx;
    pend_outcome_next = pend_outcome;
    out_valid_next    = out_valid && !result_ready;
    out_data_next     = out_data;
    item_ready        = 1'b0;
    ram_we            = 1'b0;
    ram_wdata         = '{idx: rem, sec: key_sec, ns: key_ns, slow: slow};

    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          key_ns_next = item.nanoseconds;
          slow_next   = item.slow_update;
          rem_next    = item.event_index;
          mod_k_next  = MODK_W'(MOD_STEPS - 1);
          unique case (item.kind)
            KIND_QUEUE: begin
              key_sec_next = item.seconds;
              state_next   = (MOD_STEPS > 0) ? ST_MOD : ST_APPEND;
            end
            KIND_UPDATE: begin
              key_sec_next  = item.seconds - EPOCH_SHIFT;
              mode_upd_next = 1'b1;
              state_next    = ST_READ;
            end
            KIND_SWEEP: begin
              key_sec_next  = item.seconds;
              mode_upd_next = 1'b0;
              state_next    = ST_READ;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      // One restoring subtract step of the index reduction per cycle.
      ST_MOD: begin
        if (32'(rem) >= divisor) begin
          rem_next = rem - divisor[IDX_W-1:0];
        end
        if (mod_k == '0) begin
          state_next = ST_APPEND;
        end else begin
          mod_k_next = mod_k - 1'b1;
        end
      end

      ST_APPEND: begin
        if (queue_full) begin
          pend_idx_next     = rem;
          pend_outcome_next = OUT_REFUSED;
          pend_valid_next   = 1'b1;
          state_next        = ST_FLUSH;
        end else begin
          ram_we     = 1'b1;
          tail_next  = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
          count_next = count + 1'b1;
          state_next = ST_IDLE;
        end
      end

      // The head address is stable here; its entry shows up in ST_CMP.
      ST_READ: begin
        if (count == '0) begin
          state_next = pend_valid ? ST_FLUSH : ST_IDLE;
        end else begin
          state_next = ST_CMP;
        end
      end

      // A popped entry is held back in the pending register so that the last flag
      // is known when it is handed to the output register.
      ST_CMP: begin
        if (!cmp.ge) begin
          state_next = pend_valid ? ST_FLUSH : ST_IDLE;
        end else if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = '{event_index_res: pend_idx, outcome: pend_outcome, last: 1'b0};
          end
          pend_valid_next   = 1'b1;
          pend_idx_next     = ram_rdata.idx;
          pend_outcome_next = pop_outcome;
          head_next  = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          count_next = count - 1'b1;
          state_next = (mode_upd && cmp.eq) ? ST_FLUSH : ST_READ;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_data_next   = '{event_index_res: pend_idx, outcome: pend_outcome, last: 1'b1};
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
